[rtl/oqrl_pkg.sv]
`timescale 1ns / 1ps

package oqrl_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP        = 3'd2,
        CMD_PEEK       = 3'd3,
        CMD_FIND       = 3'd4,
        CMD_REMOVE     = 3'd5,
        CMD_REMOVE_MAX = 3'd6,
        CMD_NOP        = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic decide;
        logic shift;
        logic finish;
    } dp_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic direct;
        logic scan_done;
        logic need_shift;
        logic shift_done;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/oqrl_in_if.sv]
`timescale 1ns / 1ps

interface oqrl_in_if #(
    parameter int ID_BITS   = 16,
    parameter int SIZE_BITS = 32
) ();
    logic                 valid;
    logic                 ready;
    logic [2:0]           command;
    logic [ID_BITS-1:0]   entry_id;
    logic [SIZE_BITS-1:0] entry_size;

    modport source (output valid, output command, output entry_id, output entry_size,
                    input ready);
    modport sink   (input valid, input command, input entry_id, input entry_size,
                    output ready);
endinterface

[rtl/oqrl_out_if.sv]
`timescale 1ns / 1ps

interface oqrl_out_if #(
    parameter int DEPTH     = 64,
    parameter int ID_BITS   = 16,
    parameter int SIZE_BITS = 32
) ();
    localparam int CW = $clog2(DEPTH + 1);

    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [ID_BITS-1:0]   result_id;
    logic [SIZE_BITS-1:0] result_size;
    logic [CW-1:0]        entry_count;

    modport source (output valid, output status, output result_id, output result_size,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input result_id, input result_size,
                    input entry_count, output ready);
endinterface

[rtl/oqrl_ctrl.sv]
`timescale 1ns / 1ps

module oqrl_ctrl
    import oqrl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = stat.direct ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctrl.decide = 1'b1;
                state_next  = stat.need_shift ? S_SHIFT : S_DONE;
            end
            S_SHIFT:
            begin
                ctrl.shift = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/oqrl_dp.sv]
`timescale 1ns / 1ps

module oqrl_dp
    import oqrl_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int ID_BITS   = 16,
    parameter int SIZE_BITS = 32,
    localparam int CW       = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_ctrl_t             ctrl,
    output dp_stat_t             stat,
    input  logic [2:0]           in_command,
    input  logic [ID_BITS-1:0]   in_id,
    input  logic [SIZE_BITS-1:0] in_size,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [1:0]           out_status,
    output logic [ID_BITS-1:0]   out_id,
    output logic [SIZE_BITS-1:0] out_size,
    output logic [CW-1:0]        out_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = CW + 1;
    localparam int EW = ID_BITS + SIZE_BITS;

    // ring buffer storage, one write and one registered read port
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    cmd_t          cmd_reg, cmd_next;
    logic [ID_BITS-1:0] id_reg, id_next;

    logic [CW-1:0] limit_reg, limit_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic [CW-1:0] ridx_reg, ridx_next;
    logic          rvld_reg, rvld_next;
    logic [CW-1:0] wr_idx_reg, wr_idx_next;

    logic                 found_reg, found_next;
    logic [CW-1:0]        sel_pos_reg, sel_pos_next;
    logic [ID_BITS-1:0]   sel_id_reg, sel_id_next;
    logic [SIZE_BITS-1:0] sel_size_reg, sel_size_next;

    status_t              res_status_reg, res_status_next;
    logic [ID_BITS-1:0]   res_id_reg, res_id_next;
    logic [SIZE_BITS-1:0] res_size_reg, res_size_next;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [ID_BITS-1:0]   out_id_reg, out_id_next;
    logic [SIZE_BITS-1:0] out_size_reg, out_size_next;
    logic [CW-1:0]        out_count_reg, out_count_next;

    cmd_t                 cmd_in;
    logic                 full;
    logic                 empty;
    logic [ID_BITS-1:0]   rd_id;
    logic [SIZE_BITS-1:0] rd_size;
    logic                 select;
    logic                 direct_cmd;

    // logical position -> physical slot, modulo DEPTH
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] idx);
        logic [PW-1:0] sum;
        sum = PW'(base) + PW'(idx);
        if (sum >= PW'(DEPTH))
        begin
            sum = sum - PW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign cmd_in  = cmd_t'(in_command);
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_id   = rd_data_reg[EW-1:SIZE_BITS];
    assign rd_size = rd_data_reg[SIZE_BITS-1:0];

    always_comb
    begin
        case (cmd_in)
            CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_NOP: direct_cmd = 1'b1;
            default:                                direct_cmd = empty;
        endcase
    end

    assign stat.direct     = direct_cmd;
    assign stat.scan_done  = rvld_reg && (ridx_reg == limit_reg - CW'(1));
    assign stat.need_shift = ((cmd_reg == CMD_REMOVE) && found_reg)
                             || (cmd_reg == CMD_REMOVE_MAX);
    assign stat.shift_done = !(issue_reg < count_reg) && !rvld_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // pick the returned entry during a scan
    always_comb
    begin
        case (cmd_reg)
            CMD_FIND, CMD_REMOVE: select = !found_reg && (rd_id == id_reg);
            CMD_REMOVE_MAX:       select = (ridx_reg == '0) || (rd_size > sel_size_reg);
            default:              select = 1'b1;
        endcase
    end

    always_comb
    begin
        we              = 1'b0;
        waddr           = head_reg;
        wdata           = {in_id, in_size};
        re              = 1'b0;
        raddr           = head_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        limit_next      = limit_reg;
        issue_next      = issue_reg;
        ridx_next       = ridx_reg;
        rvld_next       = rvld_reg;
        wr_idx_next     = wr_idx_reg;
        found_next      = found_reg;
        sel_pos_next    = sel_pos_reg;
        sel_id_next     = sel_id_reg;
        sel_size_next   = sel_size_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_size_next   = res_size_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_size_next   = out_size_reg;
        out_count_next  = out_count_reg;

        if (ctrl.accept)
        begin
            cmd_next        = cmd_in;
            id_next         = in_id;
            found_next      = 1'b0;
            issue_next      = '0;
            rvld_next       = 1'b0;
            limit_next      = ((cmd_in == CMD_POP) || (cmd_in == CMD_PEEK)) ? CW'(1)
                                                                           : count_reg;
            res_status_next = ST_OK;
            res_id_next     = '0;
            res_size_next   = '0;
            case (cmd_in)
                CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = phys(head_reg, count_reg);
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        head_next  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
                        we         = 1'b1;
                        waddr      = head_next;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_POP, CMD_PEEK, CMD_REMOVE_MAX:
                begin
                    if (empty)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                end
                CMD_FIND, CMD_REMOVE:
                begin
                    if (empty)
                    begin
                        res_status_next = ST_MISSING;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (ctrl.scan)
        begin
            if (issue_reg < limit_reg)
            begin
                re         = 1'b1;
                raddr      = phys(head_reg, issue_reg);
                issue_next = issue_reg + CW'(1);
                ridx_next  = issue_reg;
                rvld_next  = 1'b1;
            end
            else
            begin
                rvld_next = 1'b0;
            end
            if (rvld_reg && select)
            begin
                found_next    = 1'b1;
                sel_pos_next  = ridx_reg;
                sel_id_next   = rd_id;
                sel_size_next = rd_size;
            end
        end

        if (ctrl.decide)
        begin
            rvld_next   = 1'b0;
            issue_next  = sel_pos_reg + CW'(1);
            wr_idx_next = sel_pos_reg;
            case (cmd_reg)
                CMD_PEEK, CMD_REMOVE_MAX:
                begin
                    res_id_next   = sel_id_reg;
                    res_size_next = sel_size_reg;
                end
                CMD_POP:
                begin
                    res_id_next   = sel_id_reg;
                    res_size_next = sel_size_reg;
                    head_next     = phys(head_reg, CW'(1));
                    count_next    = count_reg - CW'(1);
                end
                CMD_FIND:
                begin
                    res_status_next = found_reg ? ST_OK : ST_MISSING;
                end
                CMD_REMOVE:
                begin
                    if (found_reg)
                    begin
                        res_id_next   = sel_id_reg;
                        res_size_next = sel_size_reg;
                    end
                    else
                    begin
                        res_status_next = ST_MISSING;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // close the gap: read position k+1, write it to k in the following cycle
        if (ctrl.shift)
        begin
            if (issue_reg < count_reg)
            begin
                re         = 1'b1;
                raddr      = phys(head_reg, issue_reg);
                issue_next = issue_reg + CW'(1);
                rvld_next  = 1'b1;
            end
            else
            begin
                rvld_next = 1'b0;
            end
            if (rvld_reg)
            begin
                we          = 1'b1;
                waddr       = phys(head_reg, wr_idx_reg);
                wdata       = rd_data_reg;
                wr_idx_next = wr_idx_reg + CW'(1);
            end
            if (stat.shift_done)
            begin
                count_next = count_reg - CW'(1);
            end
        end

        if (ctrl.finish)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_id_next     = res_id_reg;
            out_size_next   = res_size_reg;
            out_count_next  = count_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            rvld_reg      <= rvld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        limit_reg      <= limit_next;
        issue_reg      <= issue_next;
        ridx_reg       <= ridx_next;
        wr_idx_reg     <= wr_idx_next;
        found_reg      <= found_next;
        sel_pos_reg    <= sel_pos_next;
        sel_id_reg     <= sel_id_next;
        sel_size_reg   <= sel_size_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_size_reg   <= res_size_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_size_reg   <= out_size_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_id     = out_id_reg;
    assign out_size   = out_size_reg;
    assign out_count  = out_count_reg;

endmodule

[rtl/ordered_queue_with_remove_largest_core.sv]
`timescale 1ns / 1ps

// Ordered list of up to DEPTH entries (identifier and size) kept in a ring buffer
// with one read and one write port. One command item is taken at a time and gives
// one result item.
// Push back, push front, and any command that fails at once on a full or empty
// list go straight to the result. Pop and peek read the front slot. Find scans
// every held entry, one memory read a cycle. Remove and remove-largest scan the
// same way and then, when an entry is taken, move each entry behind it up by one
// slot, one read and one write a cycle. The single read port of the entry memory
// sets this pace. The result sits in an output register, so the next command is
// taken while the previous result waits to be picked up.
module ordered_queue_with_remove_largest_core
    import oqrl_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int ID_BITS   = 16,
    parameter int SIZE_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    oqrl_in_if.sink      in_ch,
    oqrl_out_if.source   out_ch
);

    localparam int CW = $clog2(DEPTH + 1);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    oqrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    oqrl_dp #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .in_command (in_ch.command),
        .in_id      (in_ch.entry_id),
        .in_size    (in_ch.entry_size),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_status (out_ch.status),
        .out_id     (out_ch.result_id),
        .out_size   (out_ch.result_size),
        .out_count  (out_ch.entry_count)
    );

    // busy right after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input ready one cycle after an accepted item");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.entry_count <= CW'(DEPTH)))
        else $error("entry count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status == ST_FULL)) |-> (out_ch.entry_count == CW'(DEPTH)))
        else $error("full status with free slots");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status == ST_EMPTY)) |-> (out_ch.entry_count == '0))
        else $error("empty status with entries held");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status != ST_OK))
            |-> ((out_ch.result_id == '0) && (out_ch.result_size == '0)))
        else $error("failed command returned entry data");

endmodule
